// ----- src/bbwm_pkg.sv -----
// Shared widths, constants and beat types for the billboard world matrix block.
// Used by every other file of the block; depends on nothing.
package bbwm_pkg;

  // Number format of coordinates, radius and matrix entries.
  localparam int FRACTION_BITS = 16;

  localparam int CW    = 32;                 // coordinate width
  localparam int DW    = CW + 1;             // exact difference width
  localparam int MW    = CW;                 // difference magnitude width
  localparam int LSW   = $clog2(MW);         // leading-one position width
  localparam int NW    = MW - 1;             // normalized magnitude width
  localparam int SQW   = 2 * NW;             // square width
  localparam int SUMW  = SQW + 2;            // sum of up to three squares
  localparam int ROOTW = SUMW / 2;           // integer square root width
  localparam int RADW  = 31;                 // radius width
  localparam int QW    = FRACTION_BITS + 1;  // trig magnitude width, up to 1.0
  localparam int QSW   = $clog2(QW);         // quotient bit position width
  localparam int DIVW  = FRACTION_BITS + ROOTW + 2;
  localparam int PW    = RADW + QW;          // radius product width
  localparam int EW    = 32;                 // matrix entry width
  localparam int SQRT_STEPS = ROOTW;
  localparam int DIV_STEPS  = QW;

  // Side data that rides along the square root pipeline.
  typedef struct packed {
    logic [NW-1:0]   num_sy;
    logic [NW-1:0]   num_cy;
    logic [NW-1:0]   num_sx;
    logic            neg_x;
    logic            neg_y;
    logic            neg_z;
    logic [RADW-1:0] radius;
    logic            degen;
  } sqrt_side_t;

  // Input beat as one packed word.
  typedef struct packed {
    logic signed [CW-1:0] camera_x;
    logic signed [CW-1:0] camera_y;
    logic signed [CW-1:0] camera_z;
    logic signed [CW-1:0] particle_x;
    logic signed [CW-1:0] particle_y;
    logic signed [CW-1:0] particle_z;
    logic [RADW-1:0]      particle_radius;
  } in_item_t;

  // Front end result: sums of squares ready for the root extraction.
  typedef struct packed {
    logic [SUMW-1:0] flat2;
    logic [SUMW-1:0] flatx2;
    logic [SUMW-1:0] total2;
    sqrt_side_t      side;
  } front_t;

  // Square root result: the three distances.
  typedef struct packed {
    logic [ROOTW-1:0] flat;
    logic [ROOTW-1:0] flatx;
    logic [ROOTW-1:0] total;
    sqrt_side_t       side;
  } root_t;

  // Side data that rides along the divider pipeline.
  typedef struct packed {
    logic            neg_x;
    logic            neg_y;
    logic            neg_z;
    logic [RADW-1:0] radius;
    logic            degen;
  } trig_side_t;

  // Divider result: cosine and sine magnitudes.
  typedef struct packed {
    logic [QW-1:0] q_cy;
    logic [QW-1:0] q_sy;
    logic [QW-1:0] q_cx;
    logic [QW-1:0] q_sx;
    trig_side_t    side;
  } trig_t;

  // Result beat.
  typedef struct packed {
    logic signed [EW-1:0] row1_col1;
    logic signed [EW-1:0] row1_col3;
    logic signed [EW-1:0] row2_col1;
    logic signed [EW-1:0] row2_col2;
    logic signed [EW-1:0] row2_col3;
    logic signed [EW-1:0] row3_col1;
    logic signed [EW-1:0] row3_col2;
    logic signed [EW-1:0] row3_col3;
    logic                 degenerate;
  } result_t;

endpackage

// ----- src/bbwm_if.sv -----
// Valid/ready channel interfaces for the input and result beats.
// Depends on bbwm_pkg for the field widths.
interface bbwm_in_if;
  import bbwm_pkg::*;

  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] camera_x;
  logic signed [CW-1:0] camera_y;
  logic signed [CW-1:0] camera_z;
  logic signed [CW-1:0] particle_x;
  logic signed [CW-1:0] particle_y;
  logic signed [CW-1:0] particle_z;
  logic [RADW-1:0]      particle_radius;

  modport source (
    output valid, camera_x, camera_y, camera_z,
    output particle_x, particle_y, particle_z, particle_radius,
    input  ready
  );
  modport sink (
    input  valid, camera_x, camera_y, camera_z,
    input  particle_x, particle_y, particle_z, particle_radius,
    output ready
  );
endinterface

interface bbwm_out_if;
  import bbwm_pkg::*;

  logic                 valid;
  logic                 ready;
  logic signed [EW-1:0] row1_col1;
  logic signed [EW-1:0] row1_col3;
  logic signed [EW-1:0] row2_col1;
  logic signed [EW-1:0] row2_col2;
  logic signed [EW-1:0] row2_col3;
  logic signed [EW-1:0] row3_col1;
  logic signed [EW-1:0] row3_col2;
  logic signed [EW-1:0] row3_col3;
  logic                 degenerate;

  modport source (
    output valid, row1_col1, row1_col3, row2_col1, row2_col2,
    output row2_col3, row3_col1, row3_col2, row3_col3, degenerate,
    input  ready
  );
  modport sink (
    input  valid, row1_col1, row1_col3, row2_col1, row2_col2,
    input  row2_col3, row3_col1, row3_col2, row3_col3, degenerate,
    output ready
  );
endinterface

// ----- src/bbwm_front.sv -----
// Front end: differences, joint normalization, squares and sums (five stages).
// Depends on bbwm_pkg.
module bbwm_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  bbwm_pkg::in_item_t in_data,
  output logic              out_valid,
  output bbwm_pkg::front_t  out_data
);
  import bbwm_pkg::*;

  // Position of the leading one; zero for a zero word.
  function automatic logic [LSW-1:0] lead_pos(input logic [MW-1:0] v);
    logic [LSW-1:0] p;
    p = '0;
    for (int i = 0; i < MW; i++) begin
      if (v[i]) p = LSW'(i);
    end
    return p;
  endfunction

  // Shift right by one or left by the given amount.
  function automatic logic [NW-1:0] norm(input logic [MW-1:0] m, input logic rt,
                                         input logic [LSW-1:0] l);
    logic [MW-1:0] s;
    s = rt ? (m >> 1) : (m << l);
    return s[NW-1:0];
  endfunction

  logic [4:0] vld_r;

  // Stage 1: exact differences and their magnitudes.
  logic signed [DW-1:0] dx_c, dy_c, dz_c;
  logic [MW-1:0]        ax_r, ay_r, az_r;
  logic                 nx1_r, ny1_r, nz1_r, dg1_r;
  logic [RADW-1:0]      rad1_r;

  always_comb begin
    dx_c = DW'(in_data.camera_x) - DW'(in_data.particle_x);
    dy_c = DW'(in_data.camera_y) - DW'(in_data.particle_y);
    dz_c = DW'(in_data.camera_z) - DW'(in_data.particle_z);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r   <= dx_c[DW-1] ? MW'(-dx_c) : MW'(dx_c);
      ay_r   <= dy_c[DW-1] ? MW'(-dy_c) : MW'(dy_c);
      az_r   <= dz_c[DW-1] ? MW'(-dz_c) : MW'(dz_c);
      nx1_r  <= dx_c[DW-1];
      ny1_r  <= dy_c[DW-1];
      nz1_r  <= dz_c[DW-1];
      dg1_r  <= (dx_c == '0) && (dz_c == '0);
      rad1_r <= in_data.particle_radius;
    end
  end

  // Stage 2: shift amounts from the leading one of each group.
  logic [LSW-1:0]  ly_c, lx_c;
  logic [MW-1:0]   ax2_r, ay2_r, az2_r;
  logic            rty_r, rtx_r;
  logic [LSW-1:0]  shy_r, shx_r;
  sqrt_side_t      sd2_r;

  always_comb begin
    ly_c = lead_pos(ax_r | az_r);
    lx_c = lead_pos(ax_r | ay_r | az_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax2_r <= ax_r;
      ay2_r <= ay_r;
      az2_r <= az_r;
      rty_r <= (ly_c == LSW'(MW - 1));
      rtx_r <= (lx_c == LSW'(MW - 1));
      shy_r <= LSW'(NW - 1) - ly_c;
      shx_r <= LSW'(NW - 1) - lx_c;
      sd2_r <= '{num_sy: '0, num_cy: '0, num_sx: '0, neg_x: nx1_r, neg_y: ny1_r,
                 neg_z: nz1_r, radius: rad1_r, degen: dg1_r};
    end
  end

  // Stage 3: apply the shifts.
  logic [NW-1:0] yx_r, yz_r, xx_r, xy_r, xz_r;
  sqrt_side_t    sd3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      yx_r  <= norm(ax2_r, rty_r, shy_r);
      yz_r  <= norm(az2_r, rty_r, shy_r);
      xx_r  <= norm(ax2_r, rtx_r, shx_r);
      xy_r  <= norm(ay2_r, rtx_r, shx_r);
      xz_r  <= norm(az2_r, rtx_r, shx_r);
      sd3_r <= sd2_r;
    end
  end

  // Stage 4: squares; the ratio numerators join the side data here.
  logic [SQW-1:0] qyx_r, qyz_r, qxx_r, qxy_r, qxz_r;
  sqrt_side_t     sd4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      qyx_r  <= SQW'(yx_r) * SQW'(yx_r);
      qyz_r  <= SQW'(yz_r) * SQW'(yz_r);
      qxx_r  <= SQW'(xx_r) * SQW'(xx_r);
      qxy_r  <= SQW'(xy_r) * SQW'(xy_r);
      qxz_r  <= SQW'(xz_r) * SQW'(xz_r);
      sd4_r  <= '{num_sy: yx_r, num_cy: yz_r, num_sx: xy_r, neg_x: sd3_r.neg_x,
                  neg_y: sd3_r.neg_y, neg_z: sd3_r.neg_z, radius: sd3_r.radius,
                  degen: sd3_r.degen};
    end
  end

  // Stage 5: sums of squares.
  always_ff @(posedge clk) begin
    if (en) begin
      out_data.flat2  <= SUMW'(qyx_r) + SUMW'(qyz_r);
      out_data.flatx2 <= SUMW'(qxx_r) + SUMW'(qxz_r);
      out_data.total2 <= SUMW'(qxx_r) + SUMW'(qxy_r) + SUMW'(qxz_r);
      out_data.side   <= sd4_r;
    end
  end

  // Valid bits follow the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], in_valid};
    end
  end

  assign out_valid = vld_r[4];
endmodule

// ----- src/bbwm_sqrt.sv -----
// Pipelined integer square roots of the three sums, one result bit per stage.
// Depends on bbwm_pkg.
module bbwm_sqrt (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  bbwm_pkg::front_t in_data,
  output logic             out_valid,
  output bbwm_pkg::root_t  out_data
);
  import bbwm_pkg::*;

  localparam int RMW = ROOTW + 3;
  localparam int NL  = 3;

  typedef struct packed {
    logic [SUMW-1:0]  v;
    logic [RMW-1:0]   rem;
    logic [ROOTW-1:0] root;
  } sq_lane_t;

  // One digit-by-digit step: bring down two bits, try to subtract.
  function automatic sq_lane_t sq_step(input sq_lane_t a);
    sq_lane_t       b;
    logic [RMW-1:0] rem_t;
    logic [RMW-1:0] trial;
    rem_t = {a.rem[RMW-3:0], a.v[SUMW-1 -: 2]};
    trial = RMW'({a.root, 2'b01});
    b.v   = a.v << 2;
    if (rem_t >= trial) begin
      b.rem  = rem_t - trial;
      b.root = {a.root[ROOTW-2:0], 1'b1};
    end else begin
      b.rem  = rem_t;
      b.root = {a.root[ROOTW-2:0], 1'b0};
    end
    return b;
  endfunction

  sq_lane_t               init_c [NL];
  sq_lane_t               lane_r [SQRT_STEPS][NL];
  sqrt_side_t             side_r [SQRT_STEPS];
  logic [SQRT_STEPS-1:0]  vld_r;

  always_comb begin
    init_c[0] = '{v: in_data.flat2,  rem: '0, root: '0};
    init_c[1] = '{v: in_data.flatx2, rem: '0, root: '0};
    init_c[2] = '{v: in_data.total2, rem: '0, root: '0};
  end

  // One stage per root bit.
  for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_stage
    if (s == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en) begin
          for (int k = 0; k < NL; k++) lane_r[0][k] <= sq_step(init_c[k]);
          side_r[0] <= in_data.side;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en) begin
          for (int k = 0; k < NL; k++) lane_r[s][k] <= sq_step(lane_r[s-1][k]);
          side_r[s] <= side_r[s-1];
        end
      end
    end
  end

  // Valid bits follow the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[SQRT_STEPS-2:0], in_valid};
    end
  end

  assign out_valid      = vld_r[SQRT_STEPS-1];
  assign out_data.flat  = lane_r[SQRT_STEPS-1][0].root;
  assign out_data.flatx = lane_r[SQRT_STEPS-1][1].root;
  assign out_data.total = lane_r[SQRT_STEPS-1][2].root;
  assign out_data.side  = side_r[SQRT_STEPS-1];
endmodule

// ----- src/bbwm_div.sv -----
// Pipelined rounded ratios for the four cosines and sines, one quotient bit
// per stage. Depends on bbwm_pkg.
module bbwm_div (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  bbwm_pkg::root_t in_data,
  output logic            out_valid,
  output bbwm_pkg::trig_t out_data
);
  import bbwm_pkg::*;

  localparam int NL = 4;

  typedef struct packed {
    logic [DIVW-1:0] rem;
    logic [DIVW-1:0] den;
    logic [QW-1:0]   q;
  } dv_lane_t;

  // Restoring step for one quotient bit at the given weight.
  function automatic dv_lane_t dv_step(input dv_lane_t a, input logic [QSW-1:0] sh);
    dv_lane_t        b;
    logic [DIVW-1:0] trial;
    trial = a.den << sh;
    b     = a;
    if (a.rem >= trial) begin
      b.rem = a.rem - trial;
      b.q   = {a.q[QW-2:0], 1'b1};
    end else begin
      b.q   = {a.q[QW-2:0], 1'b0};
    end
    return b;
  endfunction

  // Rounded num / den: divide num * 2^(F+1) + den by 2 * den.
  function automatic dv_lane_t dv_init(input logic [DIVW-1:0] num,
                                       input logic [DIVW-1:0] den);
    dv_lane_t b;
    b.rem = (num << (FRACTION_BITS + 1)) + den;
    b.den = den << 1;
    b.q   = '0;
    return b;
  endfunction

  dv_lane_t             init_c [NL];
  dv_lane_t             lane_r [DIV_STEPS][NL];
  trig_side_t           side_c;
  trig_side_t           side_r [DIV_STEPS];
  logic [DIV_STEPS-1:0] vld_r;

  // Lanes: cosine Y, sine Y, cosine X, sine X.
  always_comb begin
    init_c[0] = dv_init(DIVW'(in_data.side.num_cy), DIVW'(in_data.flat));
    init_c[1] = dv_init(DIVW'(in_data.side.num_sy), DIVW'(in_data.flat));
    init_c[2] = dv_init(DIVW'(in_data.flatx),       DIVW'(in_data.total));
    init_c[3] = dv_init(DIVW'(in_data.side.num_sx), DIVW'(in_data.total));
    side_c = '{neg_x: in_data.side.neg_x, neg_y: in_data.side.neg_y,
               neg_z: in_data.side.neg_z, radius: in_data.side.radius,
               degen: in_data.side.degen};
  end

  // One stage per quotient bit, most significant first.
  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_stage
    localparam logic [QSW-1:0] SH = QSW'(DIV_STEPS - 1 - s);
    if (s == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en) begin
          for (int k = 0; k < NL; k++) lane_r[0][k] <= dv_step(init_c[k], SH);
          side_r[0] <= side_c;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en) begin
          for (int k = 0; k < NL; k++) lane_r[s][k] <= dv_step(lane_r[s-1][k], SH);
          side_r[s] <= side_r[s-1];
        end
      end
    end
  end

  // Valid bits follow the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DIV_STEPS-2:0], in_valid};
    end
  end

  assign out_valid     = vld_r[DIV_STEPS-1];
  assign out_data.q_cy = lane_r[DIV_STEPS-1][0].q;
  assign out_data.q_sy = lane_r[DIV_STEPS-1][1].q;
  assign out_data.q_cx = lane_r[DIV_STEPS-1][2].q;
  assign out_data.q_sx = lane_r[DIV_STEPS-1][3].q;
  assign out_data.side = side_r[DIV_STEPS-1];
endmodule

// ----- src/bbwm_back.sv -----
// Back end: trig products, scaling by the radius and sign assembly.
// Depends on bbwm_pkg.
module bbwm_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  bbwm_pkg::trig_t   in_data,
  output logic              out_valid,
  output bbwm_pkg::result_t out_data
);
  import bbwm_pkg::*;

  localparam int N_ENT = 8;

  // Rounded product of two trig magnitudes.
  function automatic logic [QW-1:0] tmul(input logic [QW-1:0] a, input logic [QW-1:0] b);
    logic [2*QW-1:0] p;
    p = (2*QW)'(a) * (2*QW)'(b);
    p = p + ((2*QW)'(1) << (FRACTION_BITS - 1));
    return QW'(p >> FRACTION_BITS);
  endfunction

  // Rounded product of the radius and a trig magnitude.
  function automatic logic [RADW-1:0] rmul(input logic [RADW-1:0] r, input logic [QW-1:0] m);
    logic [PW-1:0] p;
    p = PW'(r) * PW'(m);
    p = p + (PW'(1) << (FRACTION_BITS - 1));
    return RADW'(p >> FRACTION_BITS);
  endfunction

  logic [1:0] vld_r;

  // Stage 1: products of two trig values.
  logic [QW-1:0] cy_r, sy_r, cx_r, sx_r, sxsy_r, sxcy_r, cxsy_r, cxcy_r;
  trig_side_t    sd1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      cy_r   <= in_data.q_cy;
      sy_r   <= in_data.q_sy;
      cx_r   <= in_data.q_cx;
      sx_r   <= in_data.q_sx;
      sxsy_r <= tmul(in_data.q_sx, in_data.q_sy);
      sxcy_r <= tmul(in_data.q_sx, in_data.q_cy);
      cxsy_r <= tmul(in_data.q_cx, in_data.q_sy);
      cxcy_r <= tmul(in_data.q_cx, in_data.q_cy);
      sd1_r  <= in_data.side;
    end
  end

  // Stage 2: scale by the radius and settle each entry's sign.
  logic [RADW-1:0] mag_r [N_ENT];
  logic [N_ENT-1:0] neg_r;
  logic             dg2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r[0] <= rmul(sd1_r.radius, cy_r);
      mag_r[1] <= rmul(sd1_r.radius, sy_r);
      mag_r[2] <= rmul(sd1_r.radius, sxsy_r);
      mag_r[3] <= rmul(sd1_r.radius, cx_r);
      mag_r[4] <= rmul(sd1_r.radius, sxcy_r);
      mag_r[5] <= rmul(sd1_r.radius, cxsy_r);
      mag_r[6] <= rmul(sd1_r.radius, sx_r);
      mag_r[7] <= rmul(sd1_r.radius, cxcy_r);
      neg_r    <= {sd1_r.neg_z, sd1_r.neg_y, sd1_r.neg_x,
                   !(sd1_r.neg_y ^ sd1_r.neg_z), 1'b0,
                   !(sd1_r.neg_y ^ sd1_r.neg_x), !sd1_r.neg_x, sd1_r.neg_z};
      dg2_r    <= sd1_r.degen;
    end
  end

  // Signed entries; all zero in the degenerate case.
  logic signed [EW-1:0] ent_c [N_ENT];

  always_comb begin
    for (int i = 0; i < N_ENT; i++) begin
      if (dg2_r) begin
        ent_c[i] = '0;
      end else if (neg_r[i]) begin
        ent_c[i] = -EW'(mag_r[i]);
      end else begin
        ent_c[i] = EW'(mag_r[i]);
      end
    end
    out_data.row1_col1  = ent_c[0];
    out_data.row1_col3  = ent_c[1];
    out_data.row2_col1  = ent_c[2];
    out_data.row2_col2  = ent_c[3];
    out_data.row2_col3  = ent_c[4];
    out_data.row3_col1  = ent_c[5];
    out_data.row3_col2  = ent_c[6];
    out_data.row3_col3  = ent_c[7];
    out_data.degenerate = dg2_r;
  end

  // Valid bits follow the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[0], in_valid};
    end
  end

  assign out_valid = vld_r[1];
endmodule

// ----- src/billboard_world_matrix_core.sv -----
// Billboard world matrix core: camera-facing rotation and scale entries.
// Input beats carry camera and particle positions and a radius in Q16.16;
// each result beat carries the eight non-zero entries of the upper 3x3 of
// scale * rotX * rotY and a degenerate flag.
// Both channels use valid/ready; a beat moves when both are high.
// Throughput is one beat per cycle while the spare register is free.
// Between the input beat and the result beat lie five front end stages
// (difference, leading-one search, shift, square, sum), 32 square root
// stages (one root bit each), 17 divider stages (one quotient bit each),
// two back end stages (trig products, radius scaling) and the output register.
// When the horizontal distance is zero, all entries are zero and
// degenerate is set.
// Reset (rst_n low, synchronous) clears every valid bit; no beat is then
// in flight and no result is offered.
// When the receiver stalls, the output register holds its beat and one more
// beat lands in a spare register; only then does in_ch.ready drop and the
// whole pipeline hold, so nothing is lost or repeated.
// Depends on bbwm_pkg, bbwm_if, bbwm_front, bbwm_sqrt, bbwm_div, bbwm_back.
module billboard_world_matrix_core (
  input logic         clk,
  input logic         rst_n,
  bbwm_in_if.sink     in_ch,
  bbwm_out_if.source  out_ch
);
  import bbwm_pkg::*;

  logic     en;
  in_item_t in_item_c;
  logic     fr_valid, sq_valid, dv_valid, bk_valid;
  front_t   fr_data;
  root_t    sq_data;
  trig_t    dv_data;
  result_t  bk_data;

  // The pipeline moves whenever the spare register is free.
  logic     spare_valid_r;
  result_t  spare_r;
  logic     out_valid_r;
  result_t  out_r;

  assign en          = !spare_valid_r;
  assign in_ch.ready = en;

  always_comb begin
    in_item_c.camera_x        = in_ch.camera_x;
    in_item_c.camera_y        = in_ch.camera_y;
    in_item_c.camera_z        = in_ch.camera_z;
    in_item_c.particle_x      = in_ch.particle_x;
    in_item_c.particle_y      = in_ch.particle_y;
    in_item_c.particle_z      = in_ch.particle_z;
    in_item_c.particle_radius = in_ch.particle_radius;
  end

  bbwm_front u_front (
    .clk, .rst_n, .en,
    .in_valid  (in_ch.valid),
    .in_data   (in_item_c),
    .out_valid (fr_valid),
    .out_data  (fr_data)
  );

  bbwm_sqrt u_sqrt (
    .clk, .rst_n, .en,
    .in_valid  (fr_valid),
    .in_data   (fr_data),
    .out_valid (sq_valid),
    .out_data  (sq_data)
  );

  bbwm_div u_div (
    .clk, .rst_n, .en,
    .in_valid  (sq_valid),
    .in_data   (sq_data),
    .out_valid (dv_valid),
    .out_data  (dv_data)
  );

  bbwm_back u_back (
    .clk, .rst_n, .en,
    .in_valid  (dv_valid),
    .in_data   (dv_data),
    .out_valid (bk_valid),
    .out_data  (bk_data)
  );

  // Output register with a spare stage for one stalled beat.
  logic push, pop;
  assign push = en && bk_valid;
  assign pop  = out_valid_r && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r   <= 1'b0;
      spare_valid_r <= 1'b0;
    end else if (spare_valid_r) begin
      if (pop) begin
        spare_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_r && !out_ch.ready) begin
        spare_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (spare_valid_r) begin
      if (pop) out_r <= spare_r;
    end else if (push) begin
      if (out_valid_r && !out_ch.ready) begin
        spare_r <= bk_data;
      end else begin
        out_r <= bk_data;
      end
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.row1_col1  = out_r.row1_col1;
  assign out_ch.row1_col3  = out_r.row1_col3;
  assign out_ch.row2_col1  = out_r.row2_col1;
  assign out_ch.row2_col2  = out_r.row2_col2;
  assign out_ch.row2_col3  = out_r.row2_col3;
  assign out_ch.row3_col1  = out_r.row3_col1;
  assign out_ch.row3_col2  = out_r.row3_col2;
  assign out_ch.row3_col3  = out_r.row3_col3;
  assign out_ch.degenerate = out_r.degenerate;
endmodule
